### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the three-plane intersection core.
// Every macro expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define TPI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent checked in the next cycle.
`define TPI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tpi_pkg.sv
// Package for the three-plane intersection core: widths, index tables and types.
// Used by three_plane_intersection_core and its testbench; depends on nothing.
`default_nettype none

package tpi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int COORD_W   = 32;
    localparam int TOL_W     = 16;
    localparam int PROD_W    = 2 * IN_W;
    localparam int MINOR_W   = PROD_W + 1;
    localparam int TERM_W    = MINOR_W + IN_W;
    localparam int DET_W     = TERM_W;
    localparam int MAG_W     = DET_W - 1;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int CMP_W     = MAG_W + COORD_W;
    localparam int DIV_STEPS = COORD_W;
    localparam int HALF_W    = 32;

    localparam int N_PLANE = 3;
    localparam int N_COEF  = 4;
    localparam int N_MINOR = 12;
    localparam int N_TERM  = 12;
    localparam int N_DET   = 4;
    localparam int N_AXIS  = 3;

    // Minors: rows (r0, r1), columns (u, v). Entries 0..5 are rows 1,2 with column
    // pairs ab, ac, ad, bc, bd, cd; 6..8 rows 0,1 and 9..11 rows 0,2 with ab, ac, bc.
    localparam int MIN_R0 [N_MINOR] = '{1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0};
    localparam int MIN_R1 [N_MINOR] = '{2, 2, 2, 2, 2, 2, 1, 1, 1, 2, 2, 2};
    localparam int MIN_U  [N_MINOR] = '{0, 0, 0, 1, 1, 2, 0, 0, 1, 0, 0, 1};
    localparam int MIN_V  [N_MINOR] = '{1, 2, 3, 2, 3, 3, 1, 2, 2, 1, 2, 2};
    localparam logic [N_MINOR-1:0] MIN_CHECK = 12'b1111_1100_1011;

    // Cofactor terms: first-plane coefficient times a minor of planes 1 and 2.
    localparam int TERM_COEF  [N_TERM] = '{0, 1, 2, 1, 2, 3, 0, 2, 3, 0, 1, 3};
    localparam int TERM_MINOR [N_TERM] = '{3, 1, 0, 5, 4, 3, 5, 2, 1, 4, 2, 0};

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_INF   = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [N_AXIS-1:0] neg;
        logic [N_AXIS-1:0] hi;
    } div_meta_t;

endpackage

`default_nettype wire

### rtl/three_plane_intersection_core.sv
// Three-plane intersection core: Cramer's rule on Q16.16 planes in a deep pipeline.
// Depends on tpi_pkg and assert_macros.svh.
//
// Usage: each item on the s_axis channel carries three planes a*x+b*y+c*z+d=0,
// twelve signed Q16.16 words. Each item yields one item on m_axis: the point
// in tdata and the solution kind and saturation flag in tuser.
// cfg_we writes the 16-bit zero tolerance, which resets to 1; write it only
// while no item is in flight.
// An accepted item passes seven stages that form products, minors, cofactor
// terms and determinants and run the zero tests, then a restoring divider of
// 32 stages (one quotient bit each) and an output register before m_axis_tvalid.
// Throughput is one item per cycle while m_axis_tready does not stall it.
// Every stage advances together: when m_axis_tvalid is high and
// m_axis_tready low, the whole pipeline holds and s_axis_tready drops.
// Reset clears all valid bits, so the pipeline comes up empty and ready.
`default_nettype none
`include "assert_macros.svh"

module three_plane_intersection_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // plane0_a, plane0_b, plane0_c, plane0_d, plane1_a .. plane1_d, plane2_a .. plane2_d
    input  wire logic [383:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // point_x, point_y, point_z
    output logic [95:0]       m_axis_tdata,
    // kind, saturated
    output logic [2:0]        m_axis_tuser,
    input  wire logic         cfg_we,
    input  wire logic [tpi_pkg::TOL_W-1:0] cfg_wdata
);
    import tpi_pkg::*;

    localparam int NST = 7 + DIV_STEPS + 1;

    logic [TOL_W-1:0] zero_tol_reg;
    logic [NST-1:0]   vld_reg;
    logic             en;

    logic signed [IN_W-1:0] pa [N_PLANE][N_COEF];

    logic signed [PROD_W-1:0] pp_reg [N_MINOR][2];
    logic signed [PROD_W-1:0] pp_next [N_MINOR][2];
    logic signed [IN_W-1:0]   r0_s1_reg [N_COEF];
    logic                     eq_s1_reg, eq_s1_next;

    logic signed [MINOR_W-1:0] mn_reg [N_MINOR];
    logic signed [IN_W-1:0]    r0_s2_reg [N_COEF];
    logic                      eq_s2_reg;

    logic signed [MINOR_W-1:0] pl_reg [N_TERM];
    logic signed [MINOR_W-1:0] ph_reg [N_TERM];
    logic signed [MINOR_W-1:0] pl_next [N_TERM];
    logic signed [MINOR_W-1:0] ph_next [N_TERM];
    logic                      rank_s3_reg, rank_s3_next;
    logic                      eq_s3_reg;

    logic signed [TERM_W-1:0] term_reg [N_TERM];
    logic                     rank_s4_reg, eq_s4_reg;

    logic signed [DET_W-1:0] det_reg [N_DET];
    logic signed [DET_W-1:0] det_next [N_DET];
    logic                    rank_s5_reg, eq_s5_reg;

    logic [MAG_W-1:0] den_s6_reg, den_s6_next;
    logic [NUM_W-1:0] num_s6_reg [N_AXIS];
    logic [NUM_W-1:0] num_s6_next [N_AXIS];
    logic [N_AXIS-1:0] neg_s6_reg, neg_s6_next;
    kind_t            kind_s6_reg, kind_s6_next;

    logic [NUM_W-1:0]   rem_reg [DIV_STEPS+1][N_AXIS];
    logic [COORD_W-1:0] quo_reg [DIV_STEPS+1][N_AXIS];
    logic [MAG_W-1:0]   den_reg [DIV_STEPS+1];
    div_meta_t          meta_reg [DIV_STEPS+1];
    logic [N_AXIS-1:0]  hi_next;

    logic [COORD_W-1:0] pt_reg [N_AXIS];
    logic [COORD_W-1:0] pt_next [N_AXIS];
    kind_t              kind_out_reg;
    logic               sat_out_reg, sat_out_next;

    logic signed [MINOR_W-1:0] tol_m, ntol_m;
    logic signed [DET_W-1:0]   tol_d, ntol_d;
    logic signed [IN_W:0]      tol_e, ntol_e;

    assign en            = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = {pt_reg[2], pt_reg[1], pt_reg[0]};
    assign m_axis_tuser  = {sat_out_reg, kind_out_reg};

    assign tol_m  = MINOR_W'({zero_tol_reg, {FRAC_BITS{1'b0}}});
    assign ntol_m = -tol_m;
    assign tol_d  = DET_W'({zero_tol_reg, {(2 * FRAC_BITS){1'b0}}});
    assign ntol_d = -tol_d;
    assign tol_e  = (IN_W + 1)'(zero_tol_reg);
    assign ntol_e = -tol_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_tol_reg <= TOL_W'(1);
            vld_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                zero_tol_reg <= cfg_wdata;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < N_PLANE; p++)
        begin
            for (int c = 0; c < N_COEF; c++)
            begin
                pa[p][c] = s_axis_tdata[(p * N_COEF + c) * IN_W +: IN_W];
            end
        end
    end

    // Stage 1: pair products and the plane equality test.
    always_comb
    begin
        logic signed [IN_W:0] diff;
        eq_s1_next = 1'b1;
        for (int j = 0; j < N_MINOR; j++)
        begin
            pp_next[j][0] = PROD_W'(pa[MIN_R0[j]][MIN_U[j]]) * PROD_W'(pa[MIN_R1[j]][MIN_V[j]]);
            pp_next[j][1] = PROD_W'(pa[MIN_R0[j]][MIN_V[j]]) * PROD_W'(pa[MIN_R1[j]][MIN_U[j]]);
        end
        for (int p = 1; p < N_PLANE; p++)
        begin
            for (int c = 0; c < N_COEF; c++)
            begin
                diff = (IN_W + 1)'(pa[p][c]) - (IN_W + 1)'(pa[0][c]);
                if (diff > tol_e || diff < ntol_e)
                begin
                    eq_s1_next = 1'b0;
                end
            end
        end
    end

    // Stage 3: split cofactor products and the rank-two test on the minors.
    always_comb
    begin
        logic signed [MINOR_W-1:0] m;
        logic signed [HALF_W:0]    lo_op;
        logic signed [HALF_W:0]    hi_op;
        rank_s3_next = 1'b0;
        for (int t = 0; t < N_TERM; t++)
        begin
            m     = mn_reg[TERM_MINOR[t]];
            lo_op = $signed({1'b0, m[HALF_W-1:0]});
            hi_op = $signed(m[MINOR_W-1:HALF_W]);
            pl_next[t] = MINOR_W'(lo_op) * MINOR_W'(r0_s2_reg[TERM_COEF[t]]);
            ph_next[t] = MINOR_W'(hi_op) * MINOR_W'(r0_s2_reg[TERM_COEF[t]]);
        end
        for (int j = 0; j < N_MINOR; j++)
        begin
            if (MIN_CHECK[j] && (mn_reg[j] > tol_m || mn_reg[j] < ntol_m))
            begin
                rank_s3_next = 1'b1;
            end
        end
    end

    // Stage 5: the four determinants.
    always_comb
    begin
        det_next[0] = term_reg[0] - term_reg[1] + term_reg[2];
        det_next[1] = term_reg[4] - term_reg[3] - term_reg[5];
        det_next[2] = term_reg[6] - term_reg[7] + term_reg[8];
        det_next[3] = term_reg[10] - term_reg[9] - term_reg[11];
    end

    // Stage 6: zero tests, solution kind, signs and magnitudes for the divider.
    always_comb
    begin
        logic signed [DET_W-1:0] v;
        logic                    num_zero;
        num_zero = 1'b1;
        v = det_reg[0][DET_W-1] ? -det_reg[0] : det_reg[0];
        den_s6_next = v[MAG_W-1:0];
        for (int a = 0; a < N_AXIS; a++)
        begin
            v = det_reg[a+1][DET_W-1] ? -det_reg[a+1] : det_reg[a+1];
            num_s6_next[a] = {v[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            neg_s6_next[a] = det_reg[a+1][DET_W-1] ^ det_reg[0][DET_W-1];
            if (det_reg[a+1] > tol_d || det_reg[a+1] < ntol_d)
            begin
                num_zero = 1'b0;
            end
        end
        if (det_reg[0] > tol_d || det_reg[0] < ntol_d)
        begin
            kind_s6_next = KIND_POINT;
        end
        else if (num_zero && (rank_s5_reg || eq_s5_reg))
        begin
            kind_s6_next = KIND_INF;
        end
        else
        begin
            kind_s6_next = KIND_NONE;
        end
    end

    // Stage 7: flag each quotient of 2^32 or more, which saturates a point result.
    always_comb
    begin
        for (int a = 0; a < N_AXIS; a++)
        begin
            hi_next[a] = CMP_W'(num_s6_reg[a]) >= {den_s6_reg, {COORD_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg    <= pp_next;
            r0_s1_reg <= pa[0];
            eq_s1_reg <= eq_s1_next;

            for (int j = 0; j < N_MINOR; j++)
            begin
                mn_reg[j] <= MINOR_W'(pp_reg[j][0]) - MINOR_W'(pp_reg[j][1]);
            end
            r0_s2_reg <= r0_s1_reg;
            eq_s2_reg <= eq_s1_reg;

            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
            rank_s3_reg <= rank_s3_next;
            eq_s3_reg   <= eq_s2_reg;

            for (int t = 0; t < N_TERM; t++)
            begin
                term_reg[t] <= (TERM_W'(ph_reg[t]) <<< HALF_W) + TERM_W'(pl_reg[t]);
            end
            rank_s4_reg <= rank_s3_reg;
            eq_s4_reg   <= eq_s3_reg;

            det_reg     <= det_next;
            rank_s5_reg <= rank_s4_reg;
            eq_s5_reg   <= eq_s4_reg;

            den_s6_reg  <= den_s6_next;
            num_s6_reg  <= num_s6_next;
            neg_s6_reg  <= neg_s6_next;
            kind_s6_reg <= kind_s6_next;

            rem_reg[0]       <= num_s6_reg;
            for (int a = 0; a < N_AXIS; a++)
            begin
                quo_reg[0][a] <= '0;
            end
            den_reg[0]       <= den_s6_reg;
            meta_reg[0].kind <= kind_s6_reg;
            meta_reg[0].neg  <= neg_s6_reg;
            meta_reg[0].hi   <= hi_next;

            pt_reg       <= pt_next;
            kind_out_reg <= meta_reg[DIV_STEPS].kind;
            sat_out_reg  <= sat_out_next;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - g;

        logic [NUM_W-1:0]   rem_next [N_AXIS];
        logic [COORD_W-1:0] quo_next [N_AXIS];

        always_comb
        begin
            logic [CMP_W-1:0] dsh;
            logic [CMP_W:0]   diff;
            dsh = CMP_W'(den_reg[g]) << SH;
            for (int a = 0; a < N_AXIS; a++)
            begin
                diff = {1'b0, CMP_W'(rem_reg[g][a])} - {1'b0, dsh};
                if (!diff[CMP_W])
                begin
                    rem_next[a] = diff[NUM_W-1:0];
                    quo_next[a] = quo_reg[g][a] | (COORD_W'(1) << SH);
                end
                else
                begin
                    rem_next[a] = rem_reg[g][a];
                    quo_next[a] = quo_reg[g][a];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g+1]  <= rem_next;
                quo_reg[g+1]  <= quo_next;
                den_reg[g+1]  <= den_reg[g];
                meta_reg[g+1] <= meta_reg[g];
            end
        end
    end

    // Output stage: sign, saturation and zeroing of results that are not a single point.
    always_comb
    begin
        logic [COORD_W-1:0] q;
        logic               s;
        div_meta_t          mt;
        mt = meta_reg[DIV_STEPS];
        sat_out_next = 1'b0;
        for (int a = 0; a < N_AXIS; a++)
        begin
            q = quo_reg[DIV_STEPS][a];
            if (!mt.neg[a])
            begin
                s = mt.hi[a] || q[COORD_W-1];
                pt_next[a] = s ? {1'b0, {(COORD_W - 1){1'b1}}} : q;
            end
            else
            begin
                s = mt.hi[a] || (q[COORD_W-1] && (q[COORD_W-2:0] != '0));
                pt_next[a] = s ? {1'b1, {(COORD_W - 1){1'b0}}} : -q;
            end
            if (mt.kind != KIND_POINT)
            begin
                pt_next[a] = '0;
                s = 1'b0;
            end
            sat_out_next = sat_out_next || s;
        end
    end

    `TPI_ASSERT_IMP(a_nonpoint_clear, m_axis_tvalid && kind_out_reg != KIND_POINT, m_axis_tdata == '0 && !sat_out_reg, "Point or saturation set on a result without a single point.")
    `TPI_ASSERT_IMP(a_sat_clamped, m_axis_tvalid && sat_out_reg, pt_reg[0] == 32'h7FFFFFFF || pt_reg[0] == 32'h80000000 || pt_reg[1] == 32'h7FFFFFFF || pt_reg[1] == 32'h80000000 || pt_reg[2] == 32'h7FFFFFFF || pt_reg[2] == 32'h80000000, "Saturation flagged but no coordinate at a limit.")
    `TPI_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_reg[0], "Accepted item did not enter the first stage.")

endmodule

`default_nettype wire

### sim/three_plane_intersection_core_tb.sv
// Self-checking testbench for three_plane_intersection_core: solves plane triples
// by Cramer's rule in an internal predictor and checks every result item.
// Depends on tpi_pkg and the core RTL.
`timescale 1ns / 1ps

module three_plane_intersection_core_tb;

    import tpi_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         cfg_we;
    logic [TOL_W-1:0] cfg_wdata;

    logic [TOL_W-1:0] tolerance;
    logic [383:0]     plane_items[$];
    logic [98:0]      expected_points[$];
    int               errors;
    bit               calm;
    bit               hold_req;
    bit               hold_seen;
    int               hold_left;
    int               stall_cycles;

    three_plane_intersection_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [127:0] det3(
        input logic signed [127:0] a, b, c, d, e, f, g, h, i);
        return a * (e * i - f * h) - b * (d * i - f * g) + c * (d * h - e * g);
    endfunction

    function automatic bit is_zero(input logic signed [127:0] v, input int shift,
                                   input logic [TOL_W-1:0] tol);
        logic [127:0] mag;
        logic [127:0] limit;
        mag = v[127] ? -v : v;
        limit = {112'd0, tol} << shift;
        return mag <= limit;
    endfunction

    function automatic logic [32:0] solve_axis(input logic signed [127:0] num,
                                               input logic signed [127:0] den);
        logic [127:0] n;
        logic [127:0] q;
        bit           neg;
        neg = num[127] ^ den[127];
        n = (num[127] ? -num : num) << FRAC_BITS;
        q = n / (den[127] ? -den : den);
        if (!neg)
        begin
            if (q > 128'h7FFF_FFFF)
                return {1'b1, 32'h7FFF_FFFF};
            return {1'b0, q[31:0]};
        end
        if (q > 128'h8000_0000)
            return {1'b1, 32'h8000_0000};
        return {1'b0, -q[31:0]};
    endfunction

    // Returns {saturated, kind, point_z, point_y, point_x}.
    function automatic logic [98:0] intersect_planes(input logic [383:0] item,
                                                     input logic [TOL_W-1:0] tol);
        logic signed [127:0] a[3], b[3], c[3], d[3];
        logic signed [127:0] dc, dx, dy, dz;
        logic [32:0]         rx, ry, rz;
        kind_t               kind;
        bit                  rank_two;
        bit                  same;
        for (int p = 0; p < 3; p++)
        begin
            a[p] = $signed(item[128*p +: 32]);
            b[p] = $signed(item[128*p + 32 +: 32]);
            c[p] = $signed(item[128*p + 64 +: 32]);
            d[p] = $signed(item[128*p + 96 +: 32]);
        end
        dc = det3(a[0], b[0], c[0], a[1], b[1], c[1], a[2], b[2], c[2]);
        dx = -det3(b[0], c[0], d[0], b[1], c[1], d[1], b[2], c[2], d[2]);
        dy = det3(a[0], c[0], d[0], a[1], c[1], d[1], a[2], c[2], d[2]);
        dz = -det3(a[0], b[0], d[0], a[1], b[1], d[1], a[2], b[2], d[2]);
        rx = '0;
        ry = '0;
        rz = '0;
        if (!is_zero(dc, 2 * FRAC_BITS, tol))
        begin
            rx = solve_axis(dx, dc);
            ry = solve_axis(dy, dc);
            rz = solve_axis(dz, dc);
            kind = KIND_POINT;
        end
        else if (is_zero(dx, 2 * FRAC_BITS, tol) && is_zero(dy, 2 * FRAC_BITS, tol)
                 && is_zero(dz, 2 * FRAC_BITS, tol))
        begin
            rank_two = 1'b0;
            for (int p = 0; p < 3; p++)
            begin
                for (int r = p + 1; r < 3; r++)
                begin
                    if (!is_zero(a[p] * b[r] - b[p] * a[r], FRAC_BITS, tol) ||
                        !is_zero(a[p] * c[r] - c[p] * a[r], FRAC_BITS, tol) ||
                        !is_zero(b[p] * c[r] - c[p] * b[r], FRAC_BITS, tol))
                        rank_two = 1'b1;
                end
            end
            same = 1'b1;
            for (int p = 1; p < 3; p++)
            begin
                if (!is_zero(a[p] - a[0], 0, tol) || !is_zero(b[p] - b[0], 0, tol) ||
                    !is_zero(c[p] - c[0], 0, tol) || !is_zero(d[p] - d[0], 0, tol))
                    same = 1'b0;
            end
            kind = (rank_two || same) ? KIND_INF : KIND_NONE;
        end
        else
            kind = KIND_NONE;
        return {rx[32] | ry[32] | rz[32], kind, rz[31:0], ry[31:0], rx[31:0]};
    endfunction

    function automatic int small_q16();
        int v;
        v = $urandom_range(16);
        v = (v - 8) * 65536;
        if ($urandom_range(3) == 0)
            v = v + $urandom_range(65535);
        return v;
    endfunction

    function automatic logic [383:0] pack_planes(input int w[12]);
        logic [383:0] item;
        for (int k = 0; k < 12; k++)
            item[32*k +: 32] = w[k];
        return item;
    endfunction

    function automatic logic [383:0] random_planes();
        int w[12];
        int sel;
        sel = $urandom_range(99);
        for (int k = 0; k < 12; k++)
            w[k] = (sel < 25) ? int'($urandom()) : small_q16();
        if (sel >= 45 && sel < 70)
        begin
            // Third plane is the sum of the others; a shifted offset breaks consistency.
            for (int k = 0; k < 4; k++)
                w[8 + k] = w[k] + w[4 + k];
            if (sel >= 60)
                w[11] = w[11] + small_q16() + 65536;
        end
        else if (sel >= 70 && sel < 80)
        begin
            for (int k = 4; k < 12; k++)
                w[k] = w[k % 4] + int'($urandom_range(4)) - 2;
        end
        else if (sel >= 80 && sel < 88)
        begin
            for (int k = 0; k < 3; k++)
                w[4 + k] = 2 * w[k];
            w[7] = 2 * w[3] + 65536;
        end
        else if (sel >= 88)
        begin
            for (int k = 0; k < 12; k++)
                w[k] = int'($urandom_range(6)) - 3;
            w[3] = int'($urandom());
            w[7] = int'($urandom());
            w[11] = int'($urandom());
        end
        return pack_planes(w);
    endfunction

    task automatic push_directed();
        int w[12];
        w = '{default: 0};
        plane_items.push_back(pack_planes(w));
        w = '{default: 32'h7FFF_FFFF};
        plane_items.push_back(pack_planes(w));
        w = '{default: 32'h8000_0000};
        plane_items.push_back(pack_planes(w));
        w = '{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000,
              0, 0, 32'h8000_0000, 32'h8000_0000};
        plane_items.push_back(pack_planes(w));
        w = '{65536, 0, 0, -65536, 0, 65536, 0, -131072, 0, 0, 65536, -196608};
        plane_items.push_back(pack_planes(w));
        w = '{1, 0, 0, 32'h8000_0000, 0, 1, 0, 32'h7FFF_FFFF, 0, 0, 1, 65536};
        plane_items.push_back(pack_planes(w));
        w = '{-1, 0, 0, 32'h8000_0000, 0, 65536, 0, 3, 0, 0, -65536, 7};
        plane_items.push_back(pack_planes(w));
        w = '{65536, 131072, -65536, 196608, 65536, 131072, -65536, 196608,
              65536, 131072, -65536, 196608};
        plane_items.push_back(pack_planes(w));
        w = '{65536, 131072, -65536, 196608, 65537, 131072, -65536, 196607,
              65536, 131073, -65535, 196608};
        plane_items.push_back(pack_planes(w));
        w = '{65536, 0, 0, 0, 131072, 0, 0, 65536, 0, 65536, 0, 0};
        plane_items.push_back(pack_planes(w));
        w = '{65536, 0, 0, 0, 0, 65536, 0, 0, 65536, 65536, 0, 0};
        plane_items.push_back(pack_planes(w));
        w = '{65536, 0, 0, 0, 0, 65536, 0, 0, 65536, 65536, 0, 65536};
        plane_items.push_back(pack_planes(w));
        w = '{0, 0, 0, 0, 65536, 0, 0, 0, 0, 65536, 0, 0};
        plane_items.push_back(pack_planes(w));
        w = '{0, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0};
        plane_items.push_back(pack_planes(w));
        w = '{256, 0, 0, 65536, 0, 256, 0, 65536, 0, 0, 1, 65536};
        plane_items.push_back(pack_planes(w));
        w = '{256, 0, 0, 65536, 0, 256, 0, 65536, 0, 0, 2, 65536};
        plane_items.push_back(pack_planes(w));
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        tolerance <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (plane_items.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count, input bit with_hold);
        for (int k = 0; k < count / 2; k++)
            plane_items.push_back(random_planes());
        if (with_hold)
            hold_req <= ~hold_req;
        wait_drained();
        for (int k = 0; k < count - count / 2; k++)
            plane_items.push_back(random_planes());
        wait_drained();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_points.push_back(intersect_planes(s_axis_tdata, tolerance));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (plane_items.size() != 0 && (calm || $urandom_range(99) >= 9))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= plane_items.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= 300;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 9);
    end

    always @(posedge clk)
    begin
        logic [98:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("result item with no expectation: tdata=%h tuser=%h",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (m_axis_tdata[31:0] !== want[31:0])
                begin
                    $error("point_x expected %h actual %h", want[31:0], m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== want[63:32])
                begin
                    $error("point_y expected %h actual %h", want[63:32], m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tdata[95:64] !== want[95:64])
                begin
                    $error("point_z expected %h actual %h", want[95:64], m_axis_tdata[95:64]);
                    errors++;
                end
                if (m_axis_tuser[1:0] !== want[97:96])
                begin
                    $error("kind expected %0d actual %0d", want[97:96], m_axis_tuser[1:0]);
                    errors++;
                end
                if (m_axis_tuser[2] !== want[98])
                begin
                    $error("saturated expected %0d actual %0d", want[98], m_axis_tuser[2]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == 5000)
        begin
            $display("three_plane_intersection_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        tolerance = 16'd1;
        calm = 1'b0;
        hold_req = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The tolerance stays at its reset value for the first phase.
        push_directed();
        wait_drained();
        run_phase(440, 1'b1);

        write_tolerance(16'd0);
        push_directed();
        calm = 1'b1;
        run_phase(440, 1'b0);
        calm = 1'b0;

        write_tolerance(16'hFFFF);
        push_directed();
        run_phase(430, 1'b1);

        write_tolerance(TOL_W'($urandom_range(16'hFFFF)));
        run_phase(440, 1'b0);

        repeat (60) @(posedge clk);
        if (errors == 0 && expected_points.size() == 0)
            $display("three_plane_intersection_core regression: pass");
        else
            $display("three_plane_intersection_core regression: fail");
        $finish;
    end

endmodule
